// ===== design/assert_macros.svh =====
// Assertion helpers shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pst_pkg.sv =====
package pst_pkg;

    localparam int TABLE_SIZE  = 16;
    localparam int TOPIC_SLOTS = 4;
    localparam int IDX_W       = $clog2(TABLE_SIZE);
    localparam int CNT_W       = $clog2(TABLE_SIZE + 1);
    localparam int LIST_W      = 8 * TOPIC_SLOTS;
    localparam logic [7:0] EMPTY_SLOT = 8'hFF;

    typedef enum logic [2:0] {
        CMD_SUBSCRIBE   = 3'd0,
        CMD_UNSUBSCRIBE = 3'd1,
        CMD_ADVERTISE   = 3'd2,
        CMD_UNADVERTISE = 3'd3,
        CMD_REPLACE     = 3'd4,
        CMD_FIND        = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NONE      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_WRITE,
        S_SCAN,
        S_FLUSH
    } state_t;

    function automatic logic has_topic(input logic [LIST_W-1:0] list,
                                       input logic [7:0] t);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < TOPIC_SLOTS; i++)
            if (list[8*i +: 8] == t)
                hit = 1'b1;
        return hit;
    endfunction

    function automatic logic [LIST_W-1:0] insert_topic(input logic [LIST_W-1:0] list,
                                                       input logic [7:0] t);
        logic [LIST_W-1:0] res;
        logic done;
        res  = list;
        done = has_topic(list, t);
        for (int i = 0; i < TOPIC_SLOTS; i++)
            if (!done && list[8*i +: 8] == EMPTY_SLOT)
            begin
                res[8*i +: 8] = t;
                done = 1'b1;
            end
        return res;
    endfunction

    function automatic logic [LIST_W-1:0] remove_topic(input logic [LIST_W-1:0] list,
                                                       input logic [7:0] t);
        logic [LIST_W-1:0] res;
        logic [LIST_W-1:0] shifted;
        logic hit;
        res     = list;
        shifted = {EMPTY_SLOT, list[LIST_W-1:8]};
        hit     = 1'b0;
        for (int i = 0; i < TOPIC_SLOTS; i++)
        begin
            if (!hit && list[8*i +: 8] == t)
                hit = 1'b1;
            if (hit)
                res[8*i +: 8] = shifted[8*i +: 8];
        end
        return res;
    endfunction

    function automatic logic [LIST_W-1:0] unpack_list(input logic [31:0] packed_in);
        logic [LIST_W-1:0] res;
        for (int i = 0; i < TOPIC_SLOTS; i++)
            res[8*i +: 8] = (i < 4) ? packed_in[(8*i) % 32 +: 8] : EMPTY_SLOT;
        return res;
    endfunction

endpackage

// ===== design/pubsub_subscription_table.sv =====
// Channel | Ports                                              | Handshake
// command | command node_ip topic published_list subscribed_list | start & !busy
// result  | status subscriber_ip last                          | result_valid, 1 cycle
// config  | self_ip_wdata                                      | self_ip_we
//
// Lookup reads one record a cycle from the table memory (registered read)
// and stops on the first match, and busy holds until the command is done;
// a find-subscribers command whose self record has the topic then scans
// the whole table once more for subscribers.
// Reset clears the entry count, self address and control; records are
// undefined until written. The receiver cannot stall: each word shows for
// one cycle with result_valid.
module pubsub_subscription_table
    import pst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [31:0] node_ip,
    input  logic [6:0]  topic,
    input  logic [31:0] published_list,
    input  logic [31:0] subscribed_list,
    input  logic        self_ip_we,
    input  logic [31:0] self_ip_wdata,
    output logic        result_valid,
    output logic [1:0]  status,
    output logic [31:0] subscriber_ip,
    output logic        last
);

    // table memory: key, published list, subscribed list per entry
    logic [31:0]       key_mem [TABLE_SIZE];
    logic [LIST_W-1:0] pub_mem [TABLE_SIZE];
    logic [LIST_W-1:0] sub_mem [TABLE_SIZE];

    logic [31:0]       rd_key;
    logic [LIST_W-1:0] rd_pub, rd_sub;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] addr_reg, addr_next;   // address issued
    logic             rvld_reg, rvld_next;   // read data valid this cycle
    logic [IDX_W-1:0] ridx_reg, ridx_next;   // index of the read data
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hidx_reg, hidx_next;
    logic [LIST_W-1:0] hpub_reg, hpub_next, hsub_reg, hsub_next;
    logic [31:0]      self_reg;
    logic [2:0]       cmd_reg;
    logic [31:0]      ip_reg, pl_reg, sl_reg;
    logic [7:0]       t_reg;
    // pending subscriber held back until the next one shows or scan ends
    logic             pend_reg, pend_next;
    logic [31:0]      pip_reg, pip_next;

    logic             we;
    logic [IDX_W-1:0] widx;
    logic [31:0]      wkey;
    logic [LIST_W-1:0] wpub, wsub;
    logic [31:0]      match_key;
    logic             rd_match;

    logic             ov;
    logic [1:0]       ost;
    logic [31:0]      oip;
    logic             olast;

    // synchronous read, write-first is not needed: no overlap with writes
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[widx] <= wkey;
            pub_mem[widx] <= wpub;
            sub_mem[widx] <= wsub;
        end
        rd_key <= key_mem[addr_reg[IDX_W-1:0]];
        rd_pub <= pub_mem[addr_reg[IDX_W-1:0]];
        rd_sub <= sub_mem[addr_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            self_reg     <= '0;
            rvld_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rvld_reg     <= rvld_next;
            pend_reg     <= pend_next;
            result_valid <= ov;
            if (self_ip_we)
                self_reg <= self_ip_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        ridx_reg   <= ridx_next;
        hit_reg    <= hit_next;
        hidx_reg   <= hidx_next;
        hpub_reg   <= hpub_next;
        hsub_reg   <= hsub_next;
        pip_reg    <= pip_next;
        status        <= ost;
        subscriber_ip <= oip;
        last          <= olast;
        if (start && !busy)
        begin
            cmd_reg <= command;
            ip_reg  <= node_ip;
            t_reg   <= {1'b0, topic};
            pl_reg  <= published_list;
            sl_reg  <= subscribed_list;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign match_key = (cmd_reg == CMD_FIND) ? self_reg : ip_reg;
    assign rd_match  = rvld_reg && (rd_key == match_key);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                    state_next = S_LOOK;
            S_LOOK:
                if (!rvld_reg && addr_reg >= count_reg)
                    state_next = S_WRITE;
                else if (rd_match)
                    state_next = S_WRITE;
            S_WRITE:
                if (cmd_reg == CMD_FIND)
                    state_next = (hit_reg && has_topic(hpub_reg, t_reg)) ? S_SCAN : S_IDLE;
                else
                    state_next = S_IDLE;
            S_SCAN:
                if (!rvld_reg && addr_reg >= count_reg)
                    state_next = S_FLUSH;
            S_FLUSH:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next  = count_reg;
        addr_next   = addr_reg;
        rvld_next   = 1'b0;
        ridx_next   = addr_reg[IDX_W-1:0];
        hit_next    = hit_reg;
        hidx_next   = hidx_reg;
        hpub_next   = hpub_reg;
        hsub_next   = hsub_reg;
        pend_next   = pend_reg;
        pip_next    = pip_reg;
        we   = 1'b0;
        widx = hidx_reg;
        wkey = ip_reg;
        wpub = hpub_reg;
        wsub = hsub_reg;
        ov    = 1'b0;
        ost   = ST_DONE;
        oip   = '0;
        olast = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                addr_next   = '0;
                hit_next    = 1'b0;
                pend_next   = 1'b0;
            end
            S_LOOK:
            begin
                // issue reads while below count; stop on the first match
                if (rd_match)
                begin
                    hit_next  = 1'b1;
                    hidx_next = ridx_reg;
                    hpub_next = rd_pub;
                    hsub_next = rd_sub;
                end
                else if (addr_reg < count_reg)
                begin
                    rvld_next = 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_WRITE:
            begin
                addr_next = '0;
                if (cmd_reg == CMD_FIND)
                begin
                    if (!(hit_reg && has_topic(hpub_reg, t_reg)))
                    begin
                        ov  = 1'b1;
                        ost = ST_NONE;
                    end
                end
                else if (cmd_reg > CMD_FIND)
                    ov = 1'b1;
                else if (!hit_reg && count_reg >= CNT_W'(TABLE_SIZE))
                begin
                    ov  = 1'b1;
                    ost = ST_FULL;
                end
                else
                begin
                    ov  = 1'b1;
                    we  = 1'b1;
                    if (hit_reg)
                    begin
                        widx = hidx_reg;
                        case (cmd_reg)
                            CMD_SUBSCRIBE:   wsub = insert_topic(hsub_reg, t_reg);
                            CMD_UNSUBSCRIBE: wsub = remove_topic(hsub_reg, t_reg);
                            CMD_ADVERTISE:   wpub = insert_topic(hpub_reg, t_reg);
                            CMD_UNADVERTISE: wpub = remove_topic(hpub_reg, t_reg);
                            default:
                            begin
                                wpub = unpack_list(pl_reg);
                                wsub = unpack_list(sl_reg);
                            end
                        endcase
                    end
                    else
                    begin
                        widx = count_reg[IDX_W-1:0];
                        count_next = count_reg + 1'b1;
                        wpub = {TOPIC_SLOTS{EMPTY_SLOT}};
                        wsub = {TOPIC_SLOTS{EMPTY_SLOT}};
                        case (cmd_reg)
                            CMD_SUBSCRIBE:  wsub[7:0] = t_reg;
                            CMD_ADVERTISE:  wpub[7:0] = t_reg;
                            CMD_REPLACE:
                            begin
                                wpub = unpack_list(pl_reg);
                                wsub = unpack_list(sl_reg);
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_SCAN:
            begin
                if (addr_reg < count_reg)
                begin
                    rvld_next = 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
                // hold one subscriber back so the final one can carry last
                if (rvld_reg && rd_key != self_reg && has_topic(rd_sub, t_reg))
                begin
                    if (pend_reg)
                    begin
                        ov    = 1'b1;
                        ost   = ST_FOUND;
                        oip   = pip_reg;
                        olast = 1'b0;
                    end
                    pend_next = 1'b1;
                    pip_next  = rd_key;
                end
            end
            S_FLUSH:
            begin
                ov = 1'b1;
                if (pend_reg)
                begin
                    ost = ST_FOUND;
                    oip = pip_reg;
                end
                else
                    ost = ST_NONE;
                pend_next = 1'b0;
            end
            default: ;
        endcase
    end

endmodule

// ===== design/pst_checker.sv =====
`include "assert_macros.svh"

module pst_checker
    import pst_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic [1:0]  status,
    input logic [31:0] subscriber_ip,
    input logic        last
);

    `CHK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy,
        "accepted command did not raise busy")
    `CHK_IMPLY(a_found_ip, clk, rst_n, result_valid && status != ST_FOUND,
        subscriber_ip == 32'd0, "subscriber address set without a find")
    `CHK_IMPLY(a_nonfound_last, clk, rst_n, result_valid && status != ST_FOUND,
        last, "single result word not flagged last")
    `CHK_NEXT(a_last_idle, clk, rst_n, result_valid && last, !result_valid,
        "word follows the last word of a command")

endmodule

bind pubsub_subscription_table pst_checker u_pst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .status       (status),
    .subscriber_ip(subscriber_ip),
    .last         (last)
);

// ===== tb/sv/pubsub_subscription_table_test.sv =====
`timescale 1ns / 1ps

module pubsub_subscription_table_test;
    import pst_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 60;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] node_ip;
        logic [6:0]  topic;
        logic [31:0] published_list;
        logic [31:0] subscribed_list;
    } table_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] subscriber_ip;
        logic        last;
    } table_word_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  command;
    logic [31:0] node_ip;
    logic [6:0]  topic;
    logic [31:0] published_list;
    logic [31:0] subscribed_list;
    logic        self_ip_we;
    logic [31:0] self_ip_wdata;
    logic        result_valid;
    logic [1:0]  status;
    logic [31:0] subscriber_ip;
    logic        last;

    pubsub_subscription_table uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .node_ip         (node_ip),
        .topic           (topic),
        .published_list  (published_list),
        .subscribed_list (subscribed_list),
        .self_ip_we      (self_ip_we),
        .self_ip_wdata   (self_ip_wdata),
        .result_valid    (result_valid),
        .status          (status),
        .subscriber_ip   (subscriber_ip),
        .last            (last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Shadow copy of the table, kept in step with accepted commands.
    logic [31:0]       shadow_self_ip;
    logic [31:0]       shadow_keys [TABLE_SIZE];
    logic [LIST_W-1:0] shadow_pub  [TABLE_SIZE];
    logic [LIST_W-1:0] shadow_sub  [TABLE_SIZE];
    int                shadow_count;

    table_cmd_t  pending_cmds[$];
    table_word_t expected_words[$];

    int  mismatch_count;
    int  cmds_sent;
    int  words_seen;
    int  found_words;
    int  full_words;
    int  idle_cycles;
    bit  send_gaps;
    int  gap_left;
    int  nodes_used;
    logic [31:0] node_pool [24];
    logic busy_at_edge;
    bit   cfg_hold;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, want %h (word %0d)", what, got, want, words_seen);
        mismatch_count++;
    endtask

    function automatic bit list_holds(input logic [LIST_W-1:0] list,
                                      input logic [7:0] t);
        for (int i = 0; i < TOPIC_SLOTS; i++)
            if (list[8*i +: 8] == t)
                return 1'b1;
        return 1'b0;
    endfunction

    // Put the topic in the first empty slot unless it is already listed.
    function automatic logic [LIST_W-1:0] list_add(input logic [LIST_W-1:0] list,
                                                   input logic [7:0] t);
        if (list_holds(list, t))
            return list;
        for (int i = 0; i < TOPIC_SLOTS; i++)
            if (list[8*i +: 8] == EMPTY_SLOT)
            begin
                list[8*i +: 8] = t;
                return list;
            end
        return list;
    endfunction

    // Drop the first copy and shift the later slots forward.
    function automatic logic [LIST_W-1:0] list_drop(input logic [LIST_W-1:0] list,
                                                    input logic [7:0] t);
        for (int i = 0; i < TOPIC_SLOTS; i++)
            if (list[8*i +: 8] == t)
            begin
                for (int k = i; k + 1 < TOPIC_SLOTS; k++)
                    list[8*k +: 8] = list[8*(k+1) +: 8];
                list[8*(TOPIC_SLOTS-1) +: 8] = EMPTY_SLOT;
                return list;
            end
        return list;
    endfunction

    function automatic int locate_node(input logic [31:0] ip);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_keys[i] == ip)
                return i;
        return -1;
    endfunction

    // Work out the words a command causes and update the shadow table.
    task automatic predict_table(input table_cmd_t c);
        table_word_t w;
        int e;
        int n;
        logic [7:0] t;
        t = {1'b0, c.topic};
        w = '0;
        if (c.command == CMD_FIND)
        begin
            e = locate_node(shadow_self_ip);
            n = 0;
            if (e >= 0 && list_holds(shadow_pub[e], t))
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_keys[i] != shadow_self_ip && list_holds(shadow_sub[i], t))
                    begin
                        w.status = ST_FOUND;
                        w.subscriber_ip = shadow_keys[i];
                        w.last = 1'b0;
                        expected_words.push_back(w);
                        n++;
                    end
            if (n == 0)
            begin
                w.status = ST_NONE;
                w.subscriber_ip = '0;
                w.last = 1'b1;
                expected_words.push_back(w);
            end
            else
                expected_words[$].last = 1'b1;
            return;
        end
        w.status = ST_DONE;
        w.last = 1'b1;
        if (c.command <= CMD_REPLACE)
        begin
            e = locate_node(c.node_ip);
            if (e < 0)
            begin
                if (shadow_count >= TABLE_SIZE)
                    w.status = ST_FULL;
                else
                begin
                    e = shadow_count;
                    shadow_count++;
                    shadow_keys[e] = c.node_ip;
                    shadow_pub[e] = '1;
                    shadow_sub[e] = '1;
                    if (c.command == CMD_SUBSCRIBE)
                        shadow_sub[e][7:0] = t;
                    else if (c.command == CMD_ADVERTISE)
                        shadow_pub[e][7:0] = t;
                end
            end
            else
                case (c.command)
                    CMD_SUBSCRIBE:   shadow_sub[e] = list_add(shadow_sub[e], t);
                    CMD_UNSUBSCRIBE: shadow_sub[e] = list_drop(shadow_sub[e], t);
                    CMD_ADVERTISE:   shadow_pub[e] = list_add(shadow_pub[e], t);
                    CMD_UNADVERTISE: shadow_pub[e] = list_drop(shadow_pub[e], t);
                    default: ;
                endcase
            if (c.command == CMD_REPLACE && e >= 0)
            begin
                shadow_pub[e] = c.published_list;
                shadow_sub[e] = c.subscribed_list;
            end
        end
        expected_words.push_back(w);
    endtask

    // Driver: hold start until accepted, insert random bursts of idling.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(start && busy_at_edge))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0 && !cfg_hold)
                begin
                    if (send_gaps && $urandom_range(0, 4) == 0)
                    begin
                        gap_left <= $urandom_range(0, 15);
                        start <= 1'b0;
                    end
                    else
                    begin
                        start           <= 1'b1;
                        command         <= pending_cmds[0].command;
                        node_ip         <= pending_cmds[0].node_ip;
                        topic           <= pending_cmds[0].topic;
                        published_list  <= pending_cmds[0].published_list;
                        subscribed_list <= pending_cmds[0].subscribed_list;
                        void'(pending_cmds.pop_front());
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: predict on acceptance, check each result word in order.
    always @(posedge clk)
    begin
        busy_at_edge <= busy;
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;
            if (start && !busy)
            begin
                predict_table({command, node_ip, topic, published_list, subscribed_list});
                cmds_sent++;
                idle_cycles = 0;
            end
            if (result_valid)
            begin
                idle_cycles = 0;
                words_seen++;
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word", subscriber_ip, 32'd0);
                else
                begin
                    if (status != expected_words[0].status)
                        report_mismatch("status", {30'd0, status},
                                        {30'd0, expected_words[0].status});
                    if (subscriber_ip != expected_words[0].subscriber_ip)
                        report_mismatch("subscriber_ip", subscriber_ip,
                                        expected_words[0].subscriber_ip);
                    if (last != expected_words[0].last)
                        report_mismatch("last", {31'd0, last},
                                        {31'd0, expected_words[0].last});
                    if (expected_words[0].status == ST_FOUND)
                        found_words++;
                    if (expected_words[0].status == ST_FULL)
                        full_words++;
                    void'(expected_words.pop_front());
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d words outstanding",
                         expected_words.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic table_cmd_t make_cmd(input cmd_t c, input logic [31:0] ip,
                                            input logic [6:0] t);
        table_cmd_t r;
        r.command = c;
        r.node_ip = ip;
        r.topic = t;
        r.published_list = $urandom();
        r.subscribed_list = $urandom();
        return r;
    endfunction

    // Slot bytes mostly from a small topic set, sometimes empty or raw noise.
    function automatic logic [31:0] make_list();
        logic [31:0] r;
        for (int i = 0; i < 4; i++)
            case ($urandom_range(0, 5))
                0, 1:    r[8*i +: 8] = EMPTY_SLOT;
                2:       r[8*i +: 8] = 8'($urandom());
                default: r[8*i +: 8] = 8'($urandom_range(0, 7));
            endcase
        return r;
    endfunction

    // Wait for all words, then let the block settle before a register write.
    task automatic drain_and_settle();
        wait (pending_cmds.size() == 0 && !start);
        wait (expected_words.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_self_ip(input logic [31:0] ip);
        @(negedge clk);
        self_ip_we    <= 1'b1;
        self_ip_wdata <= ip;
        @(negedge clk);
        self_ip_we    <= 1'b0;
        shadow_self_ip = ip;
    endtask

    task automatic random_phase(input int count);
        table_cmd_t c;
        int sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 20)
                c = make_cmd(CMD_FIND, $urandom(), 7'($urandom_range(0, 7)));
            else
            begin
                c = make_cmd(cmd_t'($urandom_range(0, 4)),
                             ($urandom_range(0, 9) == 0) ? $urandom()
                                 : node_pool[$urandom_range(0, nodes_used - 1)],
                             7'(($urandom_range(0, 9) == 0) ? $urandom()
                                 : $urandom_range(0, 7)));
                c.published_list = make_list();
                c.subscribed_list = make_list();
            end
            pending_cmds.push_back(c);
        end
    endtask

    initial
    begin
        table_cmd_t c;
        rst_n = 1'b0;
        start = 1'b0;
        command = '0;
        node_ip = '0;
        topic = '0;
        published_list = '0;
        subscribed_list = '0;
        self_ip_we = 1'b0;
        self_ip_wdata = '0;
        busy_at_edge = 1'b1;
        cfg_hold = 1'b0;
        send_gaps = 1'b1;
        gap_left = 0;
        shadow_self_ip = '0;
        shadow_count = 0;
        mismatch_count = 0;
        cmds_sent = 0;
        words_seen = 0;
        found_words = 0;
        full_words = 0;
        idle_cycles = 0;
        node_pool[0] = 32'h0000_0000;
        node_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 24; i++)
            node_pool[i] = $urandom();
        nodes_used = 6;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: self at address zero, find with no record, creation by
        // every change command, duplicate insert, full list, removal with shift.
        pending_cmds.push_back(make_cmd(CMD_FIND, 32'h0, 7'd0));
        pending_cmds.push_back(make_cmd(CMD_ADVERTISE, 32'h0, 7'd0));
        pending_cmds.push_back(make_cmd(CMD_FIND, 32'h0, 7'd0));
        pending_cmds.push_back(make_cmd(CMD_SUBSCRIBE, 32'hFFFF_FFFF, 7'd0));
        pending_cmds.push_back(make_cmd(CMD_SUBSCRIBE, 32'hFFFF_FFFF, 7'd0));
        pending_cmds.push_back(make_cmd(CMD_SUBSCRIBE, 32'h0, 7'd0));
        pending_cmds.push_back(make_cmd(CMD_FIND, 32'h0, 7'd0));
        for (int i = 1; i <= 5; i++)
            pending_cmds.push_back(make_cmd(CMD_ADVERTISE, 32'h0, 7'(i * 25)));
        pending_cmds.push_back(make_cmd(CMD_UNADVERTISE, 32'h0, 7'd25));
        pending_cmds.push_back(make_cmd(CMD_UNADVERTISE, 32'h0, 7'd127));
        pending_cmds.push_back(make_cmd(CMD_UNSUBSCRIBE, 32'h1234_5678, 7'd127));
        pending_cmds.push_back(make_cmd(CMD_UNADVERTISE, 32'h8000_0000, 7'd3));
        c = make_cmd(CMD_REPLACE, 32'hFFFF_FFFF, 7'd0);
        c.published_list = 32'hFFFF_FFFF;
        c.subscribed_list = 32'h7F00_FF7F;
        pending_cmds.push_back(c);
        c = make_cmd(CMD_REPLACE, 32'h0000_0001, 7'd127);
        c.published_list = 32'h0000_0000;
        c.subscribed_list = 32'hFFFF_FF00;
        pending_cmds.push_back(c);
        pending_cmds.push_back(make_cmd(CMD_FIND, 32'h0, 7'd0));
        pending_cmds.push_back(make_cmd(cmd_t'(3'd6), 32'h5, 7'd1));
        pending_cmds.push_back(make_cmd(cmd_t'(3'd7), 32'h6, 7'd2));
        drain_and_settle();

        // Fill the table to the brim, then ask for more.
        nodes_used = 24;
        write_self_ip(node_pool[1]);
        for (int i = 2; i < 24; i++)
            pending_cmds.push_back(make_cmd(CMD_SUBSCRIBE, node_pool[i],
                                            7'($urandom_range(0, 7))));
        pending_cmds.push_back(make_cmd(CMD_ADVERTISE, node_pool[1], 7'd0));
        random_phase(70);
        drain_and_settle();

        write_self_ip(32'hFFFF_FFFF);
        random_phase(70);
        drain_and_settle();

        write_self_ip(node_pool[$urandom_range(2, 12)]);
        random_phase(50);
        drain_and_settle();

        // Last stretch with no idling.
        send_gaps = 1'b0;
        write_self_ip(node_pool[0]);
        random_phase(50);
        drain_and_settle();

        $display("Ran %0d commands: %0d result words, %0d subscribers found, %0d refused",
                 cmds_sent, words_seen, found_words, full_words);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
